// File: hdl/crpg_pkg.sv
package crpg_pkg;

   localparam int CNT_W        = 16;
   localparam int FREQ_W       = 16;
   localparam int DUTY_W       = 16;
   localparam int PSC_W        = 11;
   localparam int PCT_W        = 7;
   localparam int PROD_W       = 22;
   localparam int RECIP_W      = 23;
   localparam int RECIP_SHIFT  = 29;
   localparam int Q_DEPTH      = 4;
   localparam int Q_PTR_W      = 2;
   localparam int Q_CNT_W      = 3;

   // ceil(2^29 / 100), exact floor division by 100 for any product below 2^22
   localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5368710);
   localparam logic [PCT_W-1:0]   DUTY_MAX  = PCT_W'(100);
   localparam logic [PCT_W-1:0]   DUTY_MIN  = PCT_W'(1);

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_SET  = 1'b1;

   localparam logic [FREQ_W-1:0] FREQ_10HZ   = FREQ_W'(0);
   localparam logic [FREQ_W-1:0] FREQ_100HZ  = FREQ_W'(1);
   localparam logic [FREQ_W-1:0] FREQ_1KHZ   = FREQ_W'(2);
   localparam logic [FREQ_W-1:0] FREQ_10KHZ  = FREQ_W'(3);
   localparam logic [FREQ_W-1:0] FREQ_100KHZ = FREQ_W'(4);
   localparam logic [FREQ_W-1:0] FREQ_1MHZ   = FREQ_W'(5);
   localparam logic [FREQ_W-1:0] FREQ_10MHZ  = FREQ_W'(6);

   typedef enum logic [1:0] {
      DIV_1    = 2'd0,
      DIV_8    = 2'd1,
      DIV_128  = 2'd2,
      DIV_1792 = 2'd3
   } div_sel_type;

   typedef struct packed {
      div_sel_type      sel;
      logic [CNT_W-1:0] period;
   } rate_type;

   typedef struct packed {
      logic             is_set;
      logic             apply;
      logic             force_low;
      div_sel_type      sel;
      logic [CNT_W-1:0] period;
      logic [CNT_W-1:0] compare;
   } entry_type;

   typedef struct packed {
      logic [Q_CNT_W-1:0] count;
      logic               empty;
   } queue_stat_type;

   typedef struct packed {
      logic stage_a_valid;
      logic stage_b_valid;
   } front_stat_type;

   function automatic rate_type rate_lookup(input logic [FREQ_W-1:0] code);
      rate_type r;
      case (code)
         FREQ_10HZ: begin
            r.sel = DIV_1792;
            r.period = CNT_W'(11160);
         end
         FREQ_1KHZ: begin
            r.sel = DIV_8;
            r.period = CNT_W'(24999);
         end
         FREQ_10KHZ: begin
            r.sel = DIV_1;
            r.period = CNT_W'(19999);
         end
         FREQ_100KHZ: begin
            r.sel = DIV_1;
            r.period = CNT_W'(1999);
         end
         FREQ_1MHZ: begin
            r.sel = DIV_1;
            r.period = CNT_W'(199);
         end
         FREQ_10MHZ: begin
            r.sel = DIV_1;
            r.period = CNT_W'(19);
         end
         default: begin
            // unknown codes fall back to 100 hz
            r.sel = DIV_128;
            r.period = CNT_W'(15624);
         end
      endcase
      return r;
   endfunction

   function automatic logic [PSC_W-1:0] div_limit(input div_sel_type sel);
      logic [PSC_W-1:0] d;
      case (sel)
         DIV_8:    d = PSC_W'(8);
         DIV_128:  d = PSC_W'(128);
         DIV_1792: d = PSC_W'(1792);
         default:  d = PSC_W'(1);
      endcase
      return d;
   endfunction

endpackage

// File: hdl/crpg_front.sv
module crpg_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_cmd,
   input  logic                        req_enable,
   input  logic [crpg_pkg::FREQ_W-1:0] req_freq_code,
   input  logic [crpg_pkg::DUTY_W-1:0] req_duty_percent,
   input  crpg_pkg::queue_stat_type    q_stat,
   output logic                        push_valid,
   output crpg_pkg::entry_type         push_entry,
   output crpg_pkg::front_stat_type    f_stat
);

   logic                         accept;
   logic [crpg_pkg::Q_CNT_W-1:0] used;
   logic                         is_set;
   logic                         changed;
   logic                         apply;
   logic [crpg_pkg::PCT_W-1:0]   duty_clamped;
   crpg_pkg::rate_type           rate;
   logic [crpg_pkg::CNT_W:0]     period_p1;
   logic [crpg_pkg::PROD_W-1:0]  prod;

   logic                          last_enable_ff, last_enable_in;
   logic [crpg_pkg::FREQ_W-1:0]   last_freq_ff, last_freq_in;
   logic [crpg_pkg::DUTY_W-1:0]   last_duty_ff, last_duty_in;

   logic                          a_valid_ff, a_valid_in;
   crpg_pkg::entry_type           a_entry_ff, a_entry_in;
   logic [crpg_pkg::PROD_W-1:0]   a_prod_ff, a_prod_in;

   logic [crpg_pkg::PROD_W+crpg_pkg::RECIP_W-1:0] quot_full;
   logic [crpg_pkg::CNT_W-1:0]                   quot;
   logic                          b_valid_ff, b_valid_in;
   crpg_pkg::entry_type           b_entry_ff, b_entry_in;

   // credit: queue occupancy plus items still in the two front stages
   assign used = q_stat.count + crpg_pkg::Q_CNT_W'(a_valid_ff)
                 + crpg_pkg::Q_CNT_W'(b_valid_ff);
   assign req_ready = used < crpg_pkg::Q_CNT_W'(crpg_pkg::Q_DEPTH);
   assign accept = req_valid & req_ready;

   always_comb begin
      is_set  = (req_cmd == crpg_pkg::CMD_SET);
      changed = (req_freq_code != last_freq_ff) || (req_duty_percent != last_duty_ff);
      apply   = is_set & req_enable & changed;

      if (req_duty_percent > crpg_pkg::DUTY_W'(crpg_pkg::DUTY_MAX)) begin
         duty_clamped = crpg_pkg::DUTY_MAX;
      end else if (req_duty_percent == '0) begin
         duty_clamped = crpg_pkg::DUTY_MIN;
      end else begin
         duty_clamped = req_duty_percent[crpg_pkg::PCT_W-1:0];
      end

      rate      = crpg_pkg::rate_lookup(req_freq_code);
      period_p1 = {1'b0, rate.period} + (crpg_pkg::CNT_W+1)'(1);
      prod = {{(crpg_pkg::PROD_W-crpg_pkg::CNT_W-1){1'b0}}, period_p1}
             * {{(crpg_pkg::PROD_W-crpg_pkg::PCT_W){1'b0}}, duty_clamped};

      last_enable_in = last_enable_ff;
      last_freq_in   = last_freq_ff;
      last_duty_in   = last_duty_ff;
      if (accept && is_set) begin
         last_enable_in = req_enable;
         if (apply) begin
            last_freq_in = req_freq_code;
            last_duty_in = req_duty_percent;
         end
      end

      a_valid_in          = accept;
      a_entry_in.is_set   = is_set;
      a_entry_in.apply    = apply;
      // the output is forced low exactly while the last set item disabled it
      a_entry_in.force_low = is_set ? ~req_enable : ~last_enable_ff;
      a_entry_in.sel      = rate.sel;
      a_entry_in.period   = rate.period;
      a_entry_in.compare  = '0;
      a_prod_in           = prod;
   end

   always_comb begin
      quot_full = {{crpg_pkg::RECIP_W{1'b0}}, a_prod_ff}
                  * {{crpg_pkg::PROD_W{1'b0}}, crpg_pkg::RECIP_100};
      quot = quot_full[crpg_pkg::RECIP_SHIFT +: crpg_pkg::CNT_W];

      b_valid_in = a_valid_ff;
      b_entry_in = a_entry_ff;
      if (quot > a_entry_ff.period) begin
         b_entry_in.compare = a_entry_ff.period + crpg_pkg::CNT_W'(1);
      end else begin
         b_entry_in.compare = quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_enable_ff <= 1'b0;
         last_freq_ff   <= '1;
         last_duty_ff   <= '1;
         a_valid_ff     <= 1'b0;
         b_valid_ff     <= 1'b0;
      end else begin
         last_enable_ff <= last_enable_in;
         last_freq_ff   <= last_freq_in;
         last_duty_ff   <= last_duty_in;
         a_valid_ff     <= a_valid_in;
         b_valid_ff     <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_entry_ff <= a_entry_in;
      a_prod_ff  <= a_prod_in;
      b_entry_ff <= b_entry_in;
   end

   assign push_valid           = b_valid_ff;
   assign push_entry           = b_entry_ff;
   assign f_stat.stage_a_valid = a_valid_ff;
   assign f_stat.stage_b_valid = b_valid_ff;

endmodule

// File: hdl/crpg_queue.sv
module crpg_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  crpg_pkg::entry_type      push_entry,
   input  logic                     pop,
   output crpg_pkg::entry_type      head_entry,
   output crpg_pkg::queue_stat_type q_stat
);

   crpg_pkg::entry_type          entries_ff [crpg_pkg::Q_DEPTH];
   logic [crpg_pkg::Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [crpg_pkg::Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [crpg_pkg::Q_CNT_W-1:0] count_ff, count_in;

   // the front holds back on credit, so a push never meets a full queue
   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + crpg_pkg::Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + crpg_pkg::Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + crpg_pkg::Q_CNT_W'(push_valid) - crpg_pkg::Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry   = entries_ff[rd_ptr_ff];
   assign q_stat.count = count_ff;
   assign q_stat.empty = (count_ff == '0);

endmodule

// File: hdl/crpg_back.sv
module crpg_back (
   input  logic                       clock,
   input  logic                       reset,
   input  crpg_pkg::entry_type        head_entry,
   input  crpg_pkg::queue_stat_type   q_stat,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_pwm_out,
   output logic [crpg_pkg::CNT_W-1:0] rsp_counter_value
);

   logic [crpg_pkg::PSC_W-1:0] psc_ff, psc_in;
   crpg_pkg::div_sel_type      sel_ff, sel_in;
   logic [crpg_pkg::CNT_W-1:0] base_ff, base_in;
   logic [crpg_pkg::CNT_W-1:0] period_ff, period_in;
   logic [crpg_pkg::CNT_W-1:0] compare_ff, compare_in;
   logic                       action_ff, action_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_pwm_ff, rsp_pwm_in;
   logic [crpg_pkg::CNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [crpg_pkg::PSC_W:0]   psc_p1;
   logic                       wrap;

   assign pop = ~q_stat.empty & (~rsp_valid_ff | rsp_ready);

   always_comb begin
      psc_in     = psc_ff;
      sel_in     = sel_ff;
      base_in    = base_ff;
      period_in  = period_ff;
      compare_in = compare_ff;
      action_in  = action_ff;

      psc_p1 = {1'b0, psc_ff} + (crpg_pkg::PSC_W+1)'(1);
      // prescaler may sit above a new, smaller divide; it wraps on the next tick
      wrap = psc_p1 >= {1'b0, crpg_pkg::div_limit(sel_ff)};

      if (pop) begin
         if (!head_entry.is_set) begin
            if (wrap) begin
               psc_in = '0;
               if (base_ff >= period_ff) begin
                  base_in = '0;
               end else begin
                  base_in = base_ff + crpg_pkg::CNT_W'(1);
               end
               if (base_in == '0) begin
                  action_in = 1'b1;
               end
               // compare wins over zero
               if (base_in == compare_ff) begin
                  action_in = 1'b0;
               end
            end else begin
               psc_in = psc_p1[crpg_pkg::PSC_W-1:0];
            end
         end else if (head_entry.apply) begin
            sel_in     = head_entry.sel;
            period_in  = head_entry.period;
            compare_in = head_entry.compare;
         end
      end
   end

   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_pwm_in   = pop ? (~head_entry.force_low & action_in) : rsp_pwm_ff;
      rsp_count_in = pop ? base_in : rsp_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         psc_ff       <= '0;
         sel_ff       <= crpg_pkg::DIV_1;
         base_ff      <= '0;
         period_ff    <= '0;
         compare_ff   <= '0;
         action_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         psc_ff       <= psc_in;
         sel_ff       <= sel_in;
         base_ff      <= base_in;
         period_ff    <= period_in;
         compare_ff   <= compare_in;
         action_ff    <= action_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pwm_ff   <= rsp_pwm_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pwm_out       = rsp_pwm_ff;
   assign rsp_counter_value = rsp_count_ff;

endmodule

// File: hdl/coded_rate_pwm_generator_top.sv
// coded-rate up-counting pwm generator
// req channel: one item per valid/ready handshake. req_cmd tick advances the
// prescaler and time base by one source clock; req_cmd set applies enable,
// frequency code and duty percent (fields other than cmd are ignored on ticks).
// rsp channel: exactly one item per request, in order, carrying the pin level
// and the time-base counter value after that request.
// order: the accepting edge loads the rate lookup stage, followed by compare
// scaling, queue write and output register. throughput: one item per cycle
// while a stalled rsp_ready does not hold the output, set by the single
// back-end update of the time base.
// a 4-entry queue sits between front and back; req_ready drops when queue
// entries plus items in the front stages reach 4, so a stalled rsp_ready
// backs up into req_ready with nothing dropped.
// reset (synchronous, active high) empties the pipeline and queue, selects
// divide by one with period and compare of zero, and forces the output low
// until a set item with enable high arrives.
module coded_rate_pwm_generator_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_cmd,
   input  logic                        req_enable,
   input  logic [crpg_pkg::FREQ_W-1:0] req_freq_code,
   input  logic [crpg_pkg::DUTY_W-1:0] req_duty_percent,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_pwm_out,
   output logic [crpg_pkg::CNT_W-1:0]  rsp_counter_value
);

   logic                     push_valid;
   crpg_pkg::entry_type      push_entry;
   crpg_pkg::entry_type      head_entry;
   crpg_pkg::queue_stat_type q_stat;
   crpg_pkg::front_stat_type f_stat;
   logic                     pop;

   crpg_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_enable       (req_enable),
      .req_freq_code    (req_freq_code),
      .req_duty_percent (req_duty_percent),
      .q_stat           (q_stat),
      .push_valid       (push_valid),
      .push_entry       (push_entry),
      .f_stat           (f_stat)
   );

   crpg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_stat     (q_stat)
   );

   crpg_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_entry        (head_entry),
      .q_stat            (q_stat),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pwm_out       (rsp_pwm_out),
      .rsp_counter_value (rsp_counter_value)
   );

   // credit accounting never lets the queue overcommit
   a_credit: assert property (@(posedge clock) disable iff (reset)
      (4'(q_stat.count) + 4'(f_stat.stage_a_valid) + 4'(f_stat.stage_b_valid))
         <= 4'(crpg_pkg::Q_DEPTH))
      else $error("queue credit overrun");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("pop from empty queue");

   // a response only appears after the back end took an entry
   a_rsp_from_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(pop))
      else $error("response without queue pop");

   // a push that meets a full queue would overwrite the head
   a_push_space: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (q_stat.count != crpg_pkg::Q_CNT_W'(crpg_pkg::Q_DEPTH)) || pop)
      else $error("push into full queue");

endmodule
